// ===== src/swrm_pkg.sv =====
// Shared types and constants of the sliding window rate meter.
package swrm_pkg;
   localparam int TIME_W  = 63;
   localparam int LEN_W   = 16;
   localparam int CFG_W   = 40;
   localparam int BYTES_W = 26;
   localparam int PKTS_W  = 11;
   localparam int STAT_W  = 2;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 168;

   localparam logic [STAT_W-1:0] STAT_SAMPLE   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_ORDER    = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

   localparam logic [1:0] REG_WIDTH = 2'd0;
   localparam logic [1:0] REG_STEP  = 2'd1;
   localparam logic [1:0] REG_START = 2'd2;

   localparam logic [CFG_W-1:0]  RESET_WIDTH = 40'd4294967296;
   localparam logic [CFG_W-1:0]  RESET_STEP  = 40'd214748364;
   localparam logic [TIME_W-1:0] TIME_MAX    = {TIME_W{1'b1}};

   typedef struct packed {
      logic [TIME_W-1:0]  sample_time;
      logic [BYTES_W-1:0] window_bytes;
      logic [PKTS_W-1:0]  window_packets;
      logic [TIME_W-1:0]  repeat_count;
      logic [STAT_W-1:0]  status;
   } res_type;
endpackage

// ===== src/swrm_ring.sv =====
// Packet ring memory: one write port and one registered read port.
module swrm_ring #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [swrm_pkg::TIME_W-1:0] wr_time,
   input  logic [swrm_pkg::LEN_W-1:0]  wr_len,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [swrm_pkg::TIME_W-1:0] rd_time,
   output logic [swrm_pkg::LEN_W-1:0]  rd_len
);
   logic [swrm_pkg::TIME_W+swrm_pkg::LEN_W-1:0] mem [DEPTH];
   logic [swrm_pkg::TIME_W+swrm_pkg::LEN_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_time, wr_len};
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_time = rd_ff[swrm_pkg::TIME_W+swrm_pkg::LEN_W-1:swrm_pkg::LEN_W];
   assign rd_len  = rd_ff[swrm_pkg::LEN_W-1:0];
endmodule

// ===== src/swrm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the empty gap repeat count.
module swrm_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [swrm_pkg::TIME_W-1:0] num,
   input  logic [swrm_pkg::CFG_W-1:0]  den,
   output logic                        done,
   output logic [swrm_pkg::TIME_W-1:0] quo,
   output logic [swrm_pkg::CFG_W-1:0]  rem
);
   localparam int CW = $clog2(swrm_pkg::TIME_W + 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [swrm_pkg::TIME_W-1:0] q_ff, q_in;
   logic [swrm_pkg::CFG_W:0]    r_ff, r_in;
   logic [swrm_pkg::CFG_W-1:0]  den_ff, den_in;
   logic [swrm_pkg::CFG_W:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      den_in  = den_ff;
      trial   = {r_ff[swrm_pkg::CFG_W-1:0], q_ff[swrm_pkg::TIME_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(swrm_pkg::TIME_W);
         q_in    = num;
         r_in    = '0;
         den_in  = den;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            r_in = trial - {1'b0, den_ff};
            q_in = {q_ff[swrm_pkg::TIME_W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[swrm_pkg::TIME_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      r_ff   <= r_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;
   assign rem  = r_ff[swrm_pkg::CFG_W-1:0];
endmodule

// ===== src/sliding_window_rate_meter_unit.sv =====
// Top level of the sliding window rate meter: sequencer, window state and ports.
//
//  channel  direction  beat contents
//  req      in         tdata: arrival_time, packet_length
//  rsp      out        tdata: sample_time, window_bytes, window_packets, repeat_count;
//                      tuser: status; tlast: last_of_run
//  csr      in/out     APB registers window_width, sample_step, start_time at 0, 8, 16
//
// Between accepted beats a packet with no sample passes S_ORDER, S_DIFF, S_TEST, S_INSERT,
// S_DONE, one out of order S_ORDER, S_DONE. A sample adds S_SAMPLE, S_EVREQ, S_EVCHK,
// S_DIFF, S_TEST (no S_EVCHK if it empties the window); an evicted packet S_EVREQ, S_EVCHK
// for the registered ring read; an empty gap S_GAP, S_GAPW (one-bit-per-cycle divider), S_GAPFIX.
// Reset and any register write empty the window and reload the sample time.
// A stalled rsp channel holds the sequencer once two results are waiting.
module sliding_window_rate_meter_unit #(
   parameter int WINDOW_DEPTH = 1024,
   parameter int MAX_SUBSTEPS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [swrm_pkg::REQ_DATA_W-1:0] req_tdata,   // arrival_time[62:0],
                                                        // packet_length[78:63], zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [swrm_pkg::RSP_DATA_W-1:0] rsp_tdata,   // sample_time, window_bytes,
                                                        // window_packets, repeat_count,
                                                        // zero pad
   output logic [1:0]   rsp_tuser,   // status
   output logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);
   localparam int AW  = $clog2(WINDOW_DEPTH);
   localparam int OW  = AW + 1;
   localparam int SMW = $clog2(MAX_SUBSTEPS + 1);
   localparam int CAPW = swrm_pkg::CFG_W + SMW;
   localparam int TW  = swrm_pkg::TIME_W;
   localparam int CW  = swrm_pkg::CFG_W;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_ORDER  = 4'd1;
   localparam logic [3:0] S_DIFF   = 4'd2;
   localparam logic [3:0] S_TEST   = 4'd3;
   localparam logic [3:0] S_SAMPLE = 4'd4;
   localparam logic [3:0] S_EVREQ  = 4'd5;
   localparam logic [3:0] S_EVCHK  = 4'd6;
   localparam logic [3:0] S_GAP    = 4'd7;
   localparam logic [3:0] S_GAPW   = 4'd8;
   localparam logic [3:0] S_GAPFIX = 4'd9;
   localparam logic [3:0] S_INSERT = 4'd10;
   localparam logic [3:0] S_DONE   = 4'd11;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] width_ff, width_in, step_ff, step_in;
   logic [TW-1:0] start_ff, start_in;
   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [OW-1:0] occ_ff, occ_in;
   logic [swrm_pkg::BYTES_W-1:0] bytes_ff, bytes_in;
   logic [TW-1:0] cst_ff, cst_in, last_ff, last_in;
   logic [TW-1:0] t_ff, t_in;
   logic [swrm_pkg::LEN_W-1:0] len_ff, len_in;
   logic [TW:0]   d_ff, d_in;
   logic [TW-1:0] base_ff, base_in;
   logic [CW-1:0] adj_ff, adj_in;
   logic [CW-1:0] weff_ff;
   logic          pend_ff, pend_in;
   swrm_pkg::res_type pend_res_ff, pend_res_in;
   logic          rv_ff, rv_in, rlast_ff, rlast_in;
   swrm_pkg::res_type rres_ff, rres_in;

   logic [CW-1:0]   step_eff;
   logic [CAPW-1:0] cap;
   logic [CW-1:0]   weff;
   logic            slot_free, can_put, put;
   swrm_pkg::res_type new_res;
   logic [31:0]     occ_ext;
   logic            cfg_wr;
   logic [TW:0]     sum_step, sum_gap;
   logic            div_start, div_done;
   logic [TW-1:0]   div_quo;
   logic [CW-1:0]   div_rem;
   logic            mem_wr, mem_rd;
   logic [TW-1:0]   rd_time;
   logic [swrm_pkg::LEN_W-1:0] rd_len;
   logic [AW-1:0]   head_next, tail_next;

   assign step_eff = (step_ff == '0) ? CW'(1) : step_ff;
   assign cap      = CAPW'(step_eff) * CAPW'(MAX_SUBSTEPS);
   assign weff     = (CAPW'(width_ff) < cap) ? width_ff : cap[CW-1:0];
   assign occ_ext  = 32'(occ_ff);
   assign head_next = (32'(head_ff) + 32'd1 >= 32'(WINDOW_DEPTH)) ? '0 : head_ff + 1'b1;
   assign tail_next = (32'(tail_ff) + 32'd1 >= 32'(WINDOW_DEPTH)) ? '0 : tail_ff + 1'b1;
   assign slot_free = !rv_ff || rsp_tready;
   assign can_put   = !pend_ff || slot_free;
   assign sum_step  = {1'b0, cst_ff} + (TW+1)'(step_eff);
   assign sum_gap   = {1'b0, base_ff} + (TW+1)'(adj_ff);
   assign cfg_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready;

   swrm_ring #(.DEPTH(WINDOW_DEPTH), .AW(AW)) u_ring (
      .clock(clock), .wr_en(mem_wr), .wr_addr(tail_ff), .wr_time(t_ff), .wr_len(len_ff),
      .rd_en(mem_rd), .rd_addr(head_ff), .rd_time(rd_time), .rd_len(rd_len)
   );

   swrm_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(d_ff[TW-1:0] - TW'(weff_ff) - TW'(1)), .den(step_eff),
      .done(div_done), .quo(div_quo), .rem(div_rem)
   );

   always_comb begin
      state_in = state_ff;
      width_in = width_ff;
      step_in  = step_ff;
      start_in = start_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      occ_in   = occ_ff;
      bytes_in = bytes_ff;
      cst_in   = cst_ff;
      last_in  = last_ff;
      t_in     = t_ff;
      len_in   = len_ff;
      d_in     = d_ff;
      base_in  = base_ff;
      adj_in   = adj_ff;
      pend_in  = pend_ff;
      pend_res_in = pend_res_ff;
      rv_in    = rv_ff && !rsp_tready;
      rlast_in = rlast_ff;
      rres_in  = rres_ff;
      put      = 1'b0;
      mem_wr   = 1'b0;
      mem_rd   = 1'b0;
      div_start = 1'b0;
      new_res.sample_time    = cst_ff;
      new_res.window_bytes   = bytes_ff;
      new_res.window_packets = occ_ext[swrm_pkg::PKTS_W-1:0];
      new_res.repeat_count   = '0;
      new_res.status         = swrm_pkg::STAT_SAMPLE;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               t_in     = req_tdata[TW-1:0];
               len_in   = req_tdata[TW+swrm_pkg::LEN_W-1:TW];
               state_in = S_ORDER;
            end
         end
         S_ORDER: begin
            if (occ_ff != '0 && t_ff < last_ff) begin
               new_res.status = swrm_pkg::STAT_ORDER;
               put      = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            d_in     = {1'b0, t_ff} - {1'b0, cst_ff};
            state_in = S_TEST;
         end
         S_TEST: begin
            if (!d_ff[TW] && d_ff[TW-1:0] > TW'(weff_ff)) begin
               state_in = (occ_ff == '0) ? S_GAP : S_SAMPLE;
            end else begin
               state_in = S_INSERT;
            end
         end
         S_SAMPLE: begin
            if (can_put) begin
               new_res.repeat_count = TW'(1);
               put      = 1'b1;
               cst_in   = sum_step[TW] ? swrm_pkg::TIME_MAX : sum_step[TW-1:0];
               state_in = S_EVREQ;
            end
         end
         S_EVREQ: begin
            if (occ_ff == '0) begin
               state_in = S_DIFF;
            end else begin
               mem_rd   = 1'b1;
               state_in = S_EVCHK;
            end
         end
         S_EVCHK: begin
            if (rd_time < cst_ff) begin
               bytes_in = bytes_ff - swrm_pkg::BYTES_W'(rd_len);
               head_in  = head_next;
               occ_in   = occ_ff - 1'b1;
               state_in = S_EVREQ;
            end else begin
               state_in = S_DIFF;
            end
         end
         S_GAP: begin
            div_start = 1'b1;
            base_in   = t_ff - TW'(weff_ff) - TW'(1);
            state_in  = S_GAPW;
         end
         S_GAPW: begin
            if (div_done) begin
               adj_in   = step_eff - div_rem;
               state_in = S_GAPFIX;
            end
         end
         S_GAPFIX: begin
            if (can_put) begin
               new_res.window_bytes   = '0;
               new_res.window_packets = '0;
               new_res.repeat_count   = div_quo + TW'(1);
               put      = 1'b1;
               cst_in   = sum_gap[TW] ? swrm_pkg::TIME_MAX : sum_gap[TW-1:0];
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            if (occ_ext >= 32'(WINDOW_DEPTH)) begin
               if (can_put) begin
                  new_res.status = swrm_pkg::STAT_FULL;
                  put      = 1'b1;
                  state_in = S_DONE;
               end
            end else begin
               mem_wr   = 1'b1;
               tail_in  = tail_next;
               occ_in   = occ_ff + 1'b1;
               bytes_in = bytes_ff + swrm_pkg::BYTES_W'(len_ff);
               last_in  = t_ff;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!pend_ff) begin
               state_in = S_IDLE;
            end else if (slot_free) begin
               rv_in    = 1'b1;
               rlast_in = 1'b1;
               rres_in  = pend_res_ff;
               pend_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (put) begin
         if (pend_ff) begin
            rv_in    = 1'b1;
            rlast_in = 1'b0;
            rres_in  = pend_res_ff;
         end
         pend_in     = 1'b1;
         pend_res_in = new_res;
      end

      if (cfg_wr && csr_paddr[4:3] != 2'd3) begin
         case (csr_paddr[4:3])
            swrm_pkg::REG_WIDTH: width_in = csr_pwdata[CW-1:0];
            swrm_pkg::REG_STEP:  step_in  = csr_pwdata[CW-1:0];
            default:             start_in = csr_pwdata[TW-1:0];
         endcase
         head_in  = '0;
         tail_in  = '0;
         occ_in   = '0;
         bytes_in = '0;
         cst_in   = (csr_paddr[4:3] == swrm_pkg::REG_START) ? csr_pwdata[TW-1:0] : start_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         width_ff <= swrm_pkg::RESET_WIDTH;
         step_ff  <= swrm_pkg::RESET_STEP;
         start_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         occ_ff   <= '0;
         bytes_ff <= '0;
         cst_ff   <= '0;
         pend_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         width_ff <= width_in;
         step_ff  <= step_in;
         start_ff <= start_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         occ_ff   <= occ_in;
         bytes_ff <= bytes_in;
         cst_ff   <= cst_in;
         pend_ff  <= pend_in;
         rv_ff    <= rv_in;
      end
      last_ff     <= last_in;
      t_ff        <= t_in;
      len_ff      <= len_in;
      d_ff        <= d_in;
      base_ff     <= base_in;
      adj_ff      <= adj_in;
      weff_ff     <= weff;
      pend_res_ff <= pend_res_in;
      rlast_ff    <= rlast_in;
      rres_ff     <= rres_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rv_ff;
   assign rsp_tlast  = rlast_ff;
   assign rsp_tuser  = rres_ff.status;
   assign rsp_tdata  = {5'd0, rres_ff.repeat_count, rres_ff.window_packets,
                        rres_ff.window_bytes, rres_ff.sample_time};
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_paddr[4:3])
         swrm_pkg::REG_WIDTH: csr_prdata = 64'(width_ff);
         swrm_pkg::REG_STEP:  csr_prdata = 64'(step_ff);
         swrm_pkg::REG_START: csr_prdata = 64'(start_ff);
         default:             csr_prdata = '0;
      endcase
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ext <= 32'(WINDOW_DEPTH))
      else $error("window occupancy above ring depth");
   a_empty_bytes: assert property (@(posedge clock) disable iff (reset)
      occ_ff == '0 |-> bytes_ff == '0)
      else $error("empty window holds bytes");
   a_idle_flushed: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !pend_ff)
      else $error("result left pending at idle");
   a_gap_empty: assert property (@(posedge clock) disable iff (reset)
      div_start |-> occ_ff == '0)
      else $error("gap division with packets in window");
endmodule
